>>> src/contour_ring_stitcher_core_assert.svh
// ----------------------------------------------------------------------------
// contour ring stitcher assertion macros
// shared assertion forms, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef CONTOUR_RING_STITCHER_CORE_ASSERT_SVH
`define CONTOUR_RING_STITCHER_CORE_ASSERT_SVH

// same-cycle implication
`define CRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crs check failed");

// next-cycle implication
`define CRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crs check failed");

`endif

>>> src/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// types, defaults and codes shared by the contour ring stitcher modules
// ----------------------------------------------------------------------------
package crs_pkg;

	// default sizes
	localparam int CRS_MAX_POINTS = 32;
	localparam int CRS_COORD_BITS = 16;
	localparam int CRS_ID_BITS    = 32;

	// one input word
	typedef struct packed {
		logic               kind;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
		logic        [31:0] mesh_id;
		logic               last_point;
	} crs_point_t;

	// one result word
	typedef struct packed {
		logic [31:0] face_first;
		logic [31:0] face_second;
		logic [31:0] face_third;
		logic        last_face;
		logic        overflow;
	} crs_face_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRIME0,
		ST_PRIME1,
		ST_PRIME2,
		ST_DIFF,
		ST_SQR,
		ST_SUM,
		ST_EMIT,
		ST_FILL
	} crs_state_t;

	// ring read address select
	typedef enum logic [1:0] {
		RD_ZERO,
		RD_NEXT,
		RD_AHEAD
	} crs_rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic        load;
		logic        prime;
		logic        cap_cur;
		logic        cap_nxt;
		logic        diff;
		logic        sqr;
		logic        sum;
		logic        emit;
		logic        fill;
		crs_rd_sel_t rd_sel;
	} crs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic fin;
	} crs_stat_t;

endpackage

>>> src/crs_ram.sv
// ----------------------------------------------------------------------------
// crs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module crs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl
// sequencer for point loading and the stitching loop
// ----------------------------------------------------------------------------
module crs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               kind,
	input  logic               last_point,
	input  crs_pkg::crs_stat_t stat,
	output crs_pkg::crs_cmd_t  cmd,
	output logic               busy
);
	import crs_pkg::*;

	crs_state_t state_q;
	crs_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_ZERO;
		busy       = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (kind && last_point) begin
						state_d = ST_PRIME0;
					end
				end
			end
			ST_PRIME0: begin
				cmd.prime  = 1'b1;
				cmd.rd_sel = RD_ZERO;
				state_d    = stat.empty ? ST_IDLE : ST_PRIME1;
			end
			ST_PRIME1: begin
				cmd.cap_cur = 1'b1;
				cmd.rd_sel  = RD_NEXT;
				state_d     = ST_PRIME2;
			end
			ST_PRIME2: begin
				cmd.cap_nxt = 1'b1;
				state_d     = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_SQR;
			end
			ST_SQR: begin
				cmd.sqr = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit   = 1'b1;
				cmd.rd_sel = RD_AHEAD;
				state_d    = stat.fin ? ST_IDLE : ST_FILL;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d  = ST_DIFF;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/crs_dp.sv
// ----------------------------------------------------------------------------
// crs_dp
// ring stores, cursors, squared distance pipeline and face register
// ----------------------------------------------------------------------------
module crs_dp #(
	parameter int MAX_POINTS = crs_pkg::CRS_MAX_POINTS,
	parameter int COORD_BITS = crs_pkg::CRS_COORD_BITS,
	parameter int ID_BITS    = crs_pkg::CRS_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crs_pkg::crs_cmd_t   cmd,
	input  crs_pkg::crs_point_t point,
	output crs_pkg::crs_stat_t  stat,
	output logic                face_valid,
	output crs_pkg::crs_face_t  face
);
	import crs_pkg::*;

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int WORD_W = 3 * COORD_BITS + ID_BITS;
	localparam int DW     = COORD_BITS + 1;
	localparam int SQW    = 2 * DW;
	localparam int SUMW   = SQW + 2;
	localparam int XLO    = ID_BITS + 2 * COORD_BITS;
	localparam int YLO    = ID_BITS + COORD_BITS;
	localparam int ZLO    = ID_BITS;

	// ring index step with wrap at the ring size
	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] s;
		s = CNT_W'(x) + CNT_W'(1);
		if (s == n) begin
			return '0;
		end
		return s[IDX_W-1:0];
	endfunction

	// signed coordinate difference, one bit wider
	function automatic logic signed [DW-1:0] cdiff(input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b);
		return DW'($signed(a)) - DW'($signed(b));
	endfunction

	logic [CNT_W-1:0]   lower_count_q, upper_count_q;
	logic               overflow_seen_q;
	logic [CNT_W-1:0]   na_q, nb_q, adv_a_q, adv_b_q;
	logic [IDX_W-1:0]   i_q, j_q;
	logic               ovf_pair_q, took_a_q;
	logic [WORD_W-1:0]  li_q, ln_q, uj_q, un_q;
	logic [WORD_W-1:0]  in_word, lo_rdata, up_rdata;
	logic               lo_we, up_we;
	logic [IDX_W-1:0]   lo_raddr, up_raddr;
	logic [IDX_W-1:0]   inext, jnext;
	logic signed [DW-1:0] d1x_s1, d1y_s1, d1z_s1, d2x_s1, d2y_s1, d2z_s1;
	logic [SQW-1:0]     q1x_s2, q1y_s2, q1z_s2, q2x_s2, q2y_s2, q2z_s2;
	logic [SUMW-1:0]    d1_s3, d2_s3;
	logic               force_a, force_b, take_a;
	logic [CNT_W-1:0]   adv_a_d, adv_b_d;
	logic               face_valid_q;
	crs_face_t          face_q;

	// incoming word packed for the ring store
	assign in_word = {COORD_BITS'($unsigned(point.point_x)),
		COORD_BITS'($unsigned(point.point_y)),
		COORD_BITS'($unsigned(point.point_z)),
		ID_BITS'(point.mesh_id)};

	assign lo_we = cmd.load && !point.kind && (lower_count_q < CNT_W'(MAX_POINTS));
	assign up_we = cmd.load && point.kind && (upper_count_q < CNT_W'(MAX_POINTS));

	// cursor neighbors
	assign inext = wrap_inc(i_q, na_q);
	assign jnext = wrap_inc(j_q, nb_q);

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_NEXT: begin
				lo_raddr = inext;
				up_raddr = jnext;
			end
			RD_AHEAD: begin
				lo_raddr = wrap_inc(inext, na_q);
				up_raddr = wrap_inc(jnext, nb_q);
			end
			default: begin
				lo_raddr = '0;
				up_raddr = '0;
			end
		endcase
	end

	crs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_lower_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (lower_count_q[IDX_W-1:0]),
		.wdata (in_word),
		.raddr (lo_raddr),
		.rdata (lo_rdata)
	);

	crs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_upper_ram (
		.clk   (clk),
		.we    (up_we),
		.waddr (upper_count_q[IDX_W-1:0]),
		.wdata (in_word),
		.raddr (up_raddr),
		.rdata (up_rdata)
	);

	// step decision
	assign force_a = (adv_b_q == nb_q);
	assign force_b = (adv_a_q == na_q);
	assign take_a  = force_a || (!force_b && (d1_s3 <= d2_s3));
	assign adv_a_d = take_a ? adv_a_q + CNT_W'(1) : adv_a_q;
	assign adv_b_d = take_a ? adv_b_q : adv_b_q + CNT_W'(1);

	assign stat.empty = (lower_count_q == '0) || (upper_count_q == '0);
	assign stat.fin   = (adv_a_d == na_q) && (adv_b_d == nb_q);

	// fill counts, pair flags and cursors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_count_q   <= '0;
			upper_count_q   <= '0;
			overflow_seen_q <= 1'b0;
			na_q            <= '0;
			nb_q            <= '0;
			adv_a_q         <= '0;
			adv_b_q         <= '0;
			i_q             <= '0;
			j_q             <= '0;
			ovf_pair_q      <= 1'b0;
			took_a_q        <= 1'b0;
			face_valid_q    <= 1'b0;
		end else begin
			face_valid_q <= cmd.emit;
			if (cmd.load) begin
				if (lo_we) begin
					lower_count_q <= lower_count_q + CNT_W'(1);
				end else if (up_we) begin
					upper_count_q <= upper_count_q + CNT_W'(1);
				end else begin
					overflow_seen_q <= 1'b1;
				end
			end
			if (cmd.prime) begin
				na_q            <= lower_count_q;
				nb_q            <= upper_count_q;
				ovf_pair_q      <= overflow_seen_q;
				lower_count_q   <= '0;
				upper_count_q   <= '0;
				overflow_seen_q <= 1'b0;
				adv_a_q         <= '0;
				adv_b_q         <= '0;
				i_q             <= '0;
				j_q             <= '0;
			end
			if (cmd.emit) begin
				adv_a_q  <= adv_a_d;
				adv_b_q  <= adv_b_d;
				took_a_q <= take_a;
				if (take_a) begin
					i_q <= inext;
				end else begin
					j_q <= jnext;
				end
			end
		end
	end

	// ring point registers and distance pipeline
	always_ff @(posedge clk) begin
		if (cmd.cap_cur) begin
			li_q <= lo_rdata;
			uj_q <= up_rdata;
		end
		if (cmd.cap_nxt) begin
			ln_q <= lo_rdata;
			un_q <= up_rdata;
		end
		if (cmd.emit) begin
			if (take_a) begin
				li_q <= ln_q;
			end else begin
				uj_q <= un_q;
			end
		end
		if (cmd.fill) begin
			if (took_a_q) begin
				ln_q <= lo_rdata;
			end else begin
				un_q <= up_rdata;
			end
		end
		// lower next against upper current, lower current against upper next
		if (cmd.diff) begin
			d1x_s1 <= cdiff(ln_q[XLO +: COORD_BITS], uj_q[XLO +: COORD_BITS]);
			d1y_s1 <= cdiff(ln_q[YLO +: COORD_BITS], uj_q[YLO +: COORD_BITS]);
			d1z_s1 <= cdiff(ln_q[ZLO +: COORD_BITS], uj_q[ZLO +: COORD_BITS]);
			d2x_s1 <= cdiff(li_q[XLO +: COORD_BITS], un_q[XLO +: COORD_BITS]);
			d2y_s1 <= cdiff(li_q[YLO +: COORD_BITS], un_q[YLO +: COORD_BITS]);
			d2z_s1 <= cdiff(li_q[ZLO +: COORD_BITS], un_q[ZLO +: COORD_BITS]);
		end
		if (cmd.sqr) begin
			q1x_s2 <= d1x_s1 * d1x_s1;
			q1y_s2 <= d1y_s1 * d1y_s1;
			q1z_s2 <= d1z_s1 * d1z_s1;
			q2x_s2 <= d2x_s1 * d2x_s1;
			q2y_s2 <= d2y_s1 * d2y_s1;
			q2z_s2 <= d2z_s1 * d2z_s1;
		end
		if (cmd.sum) begin
			d1_s3 <= SUMW'(q1x_s2) + SUMW'(q1y_s2) + SUMW'(q1z_s2);
			d2_s3 <= SUMW'(q2x_s2) + SUMW'(q2y_s2) + SUMW'(q2z_s2);
		end
	end

	// face output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			face_q.face_first <= 32'(li_q[ID_BITS-1:0]);
			if (take_a) begin
				face_q.face_second <= 32'(ln_q[ID_BITS-1:0]);
				face_q.face_third  <= 32'(uj_q[ID_BITS-1:0]);
			end else begin
				face_q.face_second <= 32'(uj_q[ID_BITS-1:0]);
				face_q.face_third  <= 32'(un_q[ID_BITS-1:0]);
			end
			face_q.last_face <= stat.fin;
			face_q.overflow  <= ovf_pair_q;
		end
	end

	assign face_valid = face_valid_q;
	assign face       = face_q;

endmodule

>>> src/contour_ring_stitcher_core.sv
// ----------------------------------------------------------------------------
// contour_ring_stitcher_core
// loads a lower and an upper contour ring and stitches them into a triangle
// strip by the greedy shortest-diagonal rule
// ----------------------------------------------------------------------------
//  channel  | ports                       | transfer
//  ---------+-----------------------------+-------------------------------
//  points   | start, busy, point          | start high while busy low
//  faces    | face_valid, face            | one cycle per face, no stall
//
//  a point word takes one cycle; busy stays low while points load
//  an upper point with last_point starts stitching and raises busy
//  the first face leaves after the priming reads, then one face per loop of
//  (distance difference, square, sum, decide, ring store read-back)
//  busy falls with the last face; an empty ring ends stitching after the prime step
//  the face side cannot stall; arst_n clears counts and the sequencer
// ----------------------------------------------------------------------------
module contour_ring_stitcher_core #(
	parameter int MAX_POINTS = crs_pkg::CRS_MAX_POINTS,
	parameter int COORD_BITS = crs_pkg::CRS_COORD_BITS,
	parameter int ID_BITS    = crs_pkg::CRS_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  crs_pkg::crs_point_t point,
	output logic                busy,
	output logic                face_valid,
	output crs_pkg::crs_face_t  face
);
	import crs_pkg::*;

	crs_cmd_t  cmd;
	crs_stat_t stat;

	// sequencer
	crs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (point.kind),
		.last_point (point.last_point),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy)
	);

	// ring stores and distance datapath
	crs_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.point      (point),
		.stat       (stat),
		.face_valid (face_valid),
		.face       (face)
	);

endmodule

>>> src/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker
// port-level checks on the contour ring stitcher, bound to the top level
// ----------------------------------------------------------------------------
`include "contour_ring_stitcher_core_assert.svh"

module crs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input crs_pkg::crs_point_t point,
	input logic                busy,
	input logic                face_valid,
	input crs_pkg::crs_face_t  face
);

	// faces inside a strip come while the block is still busy
	`CRS_ASSERT_NOW(a_mid_face_busy, face_valid && !face.last_face, busy)

	// the last face of a strip frees the block
	`CRS_ASSERT_NOW(a_last_face_idle, face_valid && face.last_face, !busy)

	// faces never come in adjacent cycles
	`CRS_ASSERT_NEXT(a_face_spacing, face_valid, !face_valid)

	// a lower point word leaves the block idle
	`CRS_ASSERT_NEXT(a_lower_load, start && !busy && !point.kind, !busy)

	// an upper last point starts stitching
	`CRS_ASSERT_NEXT(a_stitch_start, start && !busy && point.kind && point.last_point, busy)

endmodule

bind contour_ring_stitcher_core crs_checker u_crs_checker (.*);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// contour ring stitcher testbench
// feeds lower and upper contour rings point by point, predicts every face of
// the greedy shortest-diagonal strip and checks each face word as it leaves
// ----------------------------------------------------------------------------
module testbench;
	import crs_pkg::*;

	localparam logic KIND_LOWER   = 1'b0;
	localparam logic KIND_UPPER   = 1'b1;
	localparam int   RING_DEPTH   = CRS_MAX_POINTS;
	localparam int   SETTLE_TICKS = 20;
	localparam int   POINT_GOAL   = 255;

	// coordinate flavors for generated points
	typedef enum int {
		SPREAD_FULL,
		SPREAD_TIGHT,
		SPREAD_EDGE
	} spread_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       face_valid;
	crs_point_t point;
	crs_face_t  face;

	contour_ring_stitcher_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.point      (point),
		.busy       (busy),
		.face_valid (face_valid),
		.face       (face)
	);

	// shadow rings and pair state
	crs_point_t  lower_ring [RING_DEPTH];
	crs_point_t  upper_ring [RING_DEPTH];
	int unsigned lower_fill;
	int unsigned upper_fill;
	bit          points_dropped;
	crs_face_t   pending_faces [$];

	int error_count;
	int points_sent;
	int faces_checked;
	int strips_built;
	int overflow_strips;
	bit gaps_on;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("timeout at %0t with %0d faces outstanding", $time, pending_faces.size());
		$display("status: fail");
		$finish;
	end

	// squared distance between two ring points
	function automatic longint gap_sq(crs_point_t a, crs_point_t b);
		longint dx;
		longint dy;
		longint dz;
		dx = longint'($signed(a.point_x)) - longint'($signed(b.point_x));
		dy = longint'($signed(a.point_y)) - longint'($signed(b.point_y));
		dz = longint'($signed(a.point_z)) - longint'($signed(b.point_z));
		return dx * dx + dy * dy + dz * dz;
	endfunction

	// store one accepted point and, on the closing upper point, build the strip
	task automatic predict_faces(crs_point_t p);
		int unsigned na;
		int unsigned nb;
		int unsigned i;
		int unsigned j;
		int unsigned inext;
		int unsigned jnext;
		int unsigned adv_a;
		int unsigned adv_b;
		bit          ovf;
		bit          take_lower;
		crs_face_t   f;
		if (p.kind == KIND_UPPER) begin
			if (upper_fill < RING_DEPTH) begin
				upper_ring[upper_fill] = p;
				upper_fill++;
			end else begin
				points_dropped = 1'b1;
			end
		end else begin
			if (lower_fill < RING_DEPTH) begin
				lower_ring[lower_fill] = p;
				lower_fill++;
			end else begin
				points_dropped = 1'b1;
			end
		end
		if (!(p.kind == KIND_UPPER && p.last_point))
			return;
		na = lower_fill;
		nb = upper_fill;
		ovf = points_dropped;
		lower_fill = 0;
		upper_fill = 0;
		points_dropped = 1'b0;
		if (na == 0 || nb == 0)
			return;
		strips_built++;
		if (ovf)
			overflow_strips++;
		i = 0;
		j = 0;
		adv_a = 0;
		adv_b = 0;
		// walk both rings, shorter diagonal wins, ties go to the lower ring
		while (adv_a < na || adv_b < nb) begin
			inext = (i + 1) % na;
			jnext = (j + 1) % nb;
			if (adv_b >= nb)
				take_lower = 1'b1;
			else if (adv_a >= na)
				take_lower = 1'b0;
			else
				take_lower = gap_sq(lower_ring[inext], upper_ring[j]) <=
					gap_sq(lower_ring[i], upper_ring[jnext]);
			f.face_first = lower_ring[i].mesh_id;
			if (take_lower) begin
				adv_a++;
				f.face_second = lower_ring[inext].mesh_id;
				f.face_third  = upper_ring[j].mesh_id;
				i = inext;
			end else begin
				adv_b++;
				f.face_second = upper_ring[j].mesh_id;
				f.face_third  = upper_ring[jnext].mesh_id;
				j = jnext;
			end
			f.last_face = (adv_a >= na && adv_b >= nb);
			f.overflow  = ovf;
			pending_faces = {pending_faces, f};
		end
	endtask

	// send one point word, with a random gap ahead of it
	task automatic send_point(crs_point_t p);
		while (gaps_on && $urandom_range(99) < 37) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		points_sent++;
		predict_faces(p);
	endtask

	// hold off until every predicted face has left and the block is idle
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_faces.size() != 0 || busy)
			@(posedge clk);
	endtask

	function automatic crs_point_t ring_point(logic kind, logic [15:0] x, logic [15:0] y,
		logic [15:0] z, logic [31:0] id, logic last);
		crs_point_t p;
		p.kind       = kind;
		p.point_x    = x;
		p.point_y    = y;
		p.point_z    = z;
		p.mesh_id    = id;
		p.last_point = last;
		return p;
	endfunction

	function automatic logic [15:0] pick_coord(spread_t s);
		int v;
		case (s)
			SPREAD_TIGHT: begin
				v = int'($urandom_range(6)) - 3;
				return v[15:0];
			end
			SPREAD_EDGE: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return 16'h0000;
					default: return 16'hffff;
				endcase
			end
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic crs_point_t make_point(logic kind, spread_t s, logic last);
		return ring_point(kind, pick_coord(s), pick_coord(s), pick_coord(s), $urandom(), last);
	endfunction

	// one ring pair; the closing upper point always goes last
	task automatic send_pair(int nl, int nu, bit mixed, spread_t s);
		int rem_l;
		int rem_u;
		bit pick_lower;
		rem_l = nl;
		rem_u = nu - 1;
		while (rem_l + rem_u > 0) begin
			if (mixed)
				pick_lower = (rem_u == 0) || (rem_l != 0 && $urandom_range(1) == 0);
			else
				pick_lower = (rem_l != 0);
			if (pick_lower) begin
				send_point(make_point(KIND_LOWER, s, $urandom_range(3) == 0));
				rem_l--;
			end else begin
				send_point(make_point(KIND_UPPER, s, 1'b0));
				rem_u--;
			end
		end
		send_point(make_point(KIND_UPPER, s, 1'b1));
	endtask

	function automatic int pick_ring_size(int least);
		if (least == 0 && $urandom_range(19) == 0)
			return 0;
		if ($urandom_range(11) == 0)
			return $urandom_range(34, 20);
		return $urandom_range(7, 1);
	endfunction

	// extremes, ties, single points, empty lower ring, interleaving
	task automatic test_directed();
		send_point(ring_point(KIND_LOWER, 16'h8000, 16'h8000, 16'h8000, 32'h0000_0000, 1'b0));
		send_point(ring_point(KIND_LOWER, 16'h7fff, 16'h7fff, 16'h7fff, 32'hffff_ffff, 1'b0));
		send_point(ring_point(KIND_LOWER, 16'h0000, 16'h0000, 16'h0000, 32'h5555_5555, 1'b1));
		send_point(ring_point(KIND_UPPER, 16'h7fff, 16'h8000, 16'h0000, 32'haaaa_aaaa, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'hffff, 16'hffff, 16'hffff, 32'h0000_0001, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'h8000, 16'h7fff, 16'h7fff, 32'h8000_0000, 1'b1));
		// coincident points, every comparison is a tie
		send_point(ring_point(KIND_LOWER, 16'd5, 16'd5, 16'd5, 32'h10, 1'b0));
		send_point(ring_point(KIND_LOWER, 16'd5, 16'd5, 16'd5, 32'h11, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'd5, 16'd5, 16'd5, 32'h20, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'd5, 16'd5, 16'd5, 32'h21, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'd5, 16'd5, 16'd5, 32'h22, 1'b1));
		// one point per ring
		send_point(ring_point(KIND_LOWER, 16'hffff, 16'h0000, 16'h0001, 32'h30, 1'b1));
		send_point(ring_point(KIND_UPPER, 16'h0001, 16'h0000, 16'hffff, 32'h40, 1'b1));
		// empty lower ring gives no faces
		send_point(ring_point(KIND_UPPER, 16'h1234, 16'h4321, 16'h0f0f, 32'h50, 1'b1));
		// interleaved kinds
		send_point(ring_point(KIND_UPPER, 16'd100, 16'd0, 16'd10, 32'h60, 1'b0));
		send_point(ring_point(KIND_LOWER, 16'd0, 16'd0, 16'd0, 32'h70, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'd0, 16'd100, 16'd10, 32'h61, 1'b0));
		send_point(ring_point(KIND_LOWER, 16'd50, 16'd50, 16'd0, 32'h71, 1'b0));
		send_point(ring_point(KIND_UPPER, 16'hff9c, 16'd0, 16'd10, 32'h62, 1'b1));
		wait_drained();
	endtask

	// full rings, dropped points on either side, flag clearing
	task automatic test_full_rings();
		send_pair(32, 32, 1'b1, SPREAD_FULL);
		send_pair(34, 2, 1'b0, SPREAD_FULL);
		send_pair(3, 33, 1'b1, SPREAD_TIGHT);
		send_pair(0, 33, 1'b0, SPREAD_FULL);
		send_pair(2, 2, 1'b0, SPREAD_EDGE);
		wait_drained();
	endtask

	// each pair finishes completely before the next starts
	task automatic test_paused_pairs();
		repeat (3) begin
			send_pair($urandom_range(5, 1), $urandom_range(5, 1), 1'b1,
				spread_t'($urandom_range(2)));
			wait_drained();
		end
	endtask

	// no sender gaps at all
	task automatic test_back_to_back();
		gaps_on = 1'b0;
		repeat (3)
			send_pair($urandom_range(6, 1), $urandom_range(6, 1), 1'($urandom_range(1)),
				spread_t'($urandom_range(2)));
		gaps_on = 1'b1;
	endtask

	// random pairs, mostly small, some near or past capacity
	task automatic test_random_pairs();
		while (points_sent < POINT_GOAL) begin
			send_pair(pick_ring_size(0), pick_ring_size(1), $urandom_range(2) != 0,
				spread_t'($urandom_range(2)));
			if ($urandom_range(7) == 0)
				wait_drained();
		end
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// face word checker
	always @(posedge clk) begin : face_check
		crs_face_t want;
		if (arst_n && face_valid) begin
			if (pending_faces.size() == 0) begin
				error_count++;
				$display("%0t: unexpected face, expected none, actual %h", $time, face);
			end else begin
				want = pending_faces.pop_front();
				faces_checked++;
				check_field("face_first", want.face_first, face.face_first);
				check_field("face_second", want.face_second, face.face_second);
				check_field("face_third", want.face_third, face.face_third);
				check_field("last_face", 32'(want.last_face), 32'(face.last_face));
				check_field("overflow", 32'(want.overflow), 32'(face.overflow));
			end
		end
	end

	// test sequence
	initial begin
		error_count     = 0;
		points_sent     = 0;
		faces_checked   = 0;
		strips_built    = 0;
		overflow_strips = 0;
		lower_fill      = 0;
		upper_fill      = 0;
		points_dropped  = 1'b0;
		gaps_on         = 1'b1;
		arst_n <= 1'b0;
		start  <= 1'b0;
		point  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rings();
		test_paused_pairs();
		test_back_to_back();
		test_random_pairs();
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (pending_faces.size() != 0) begin
			error_count++;
			$display("%0t: %0d faces never arrived", $time, pending_faces.size());
		end
		$display("covered %0d points in %0d stitched strips, %0d of them with dropped points",
			points_sent, strips_built, overflow_strips);
		$display("checked %0d faces, %0d errors", faces_checked, error_count);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
